[rtl/fir_filter_ring_delay_line_macros.svh]
// Assertion macros shared by the FIR filter RTL.
`ifndef FIR_FILTER_RING_DELAY_LINE_MACROS_SVH
`define FIR_FILTER_RING_DELAY_LINE_MACROS_SVH

// Check a consequence in the same cycle as its condition.
`define FRD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its condition.
`define FRD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/frd_pkg.sv]
// Shared constants and types for the FIR filter with ring delay line.
`timescale 1ns / 1ps
package frd_pkg;

   // Default sizes
   localparam int MAX_TAPS_DEF    = 128;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF   = 18;

   // Fixed field widths
   localparam int TAPS_W = 8;
   localparam int GAIN_W = 16;
   localparam int IDX_W  = 7;

   // Post-scale arithmetic
   localparam int GAIN_FRAC = 12;
   localparam int CLAMP_W   = 48;
   localparam int HALF_W    = 24;
   localparam int Y_W       = 66;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_TAPS = 1'b0;
   localparam logic REG_GAIN = 1'b1;
   localparam logic [TAPS_W-1:0] TAPS_RST = 8'd127;
   localparam logic [GAIN_W-1:0] GAIN_RST = 16'd2867;

   // Sequencer to multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctl_type;

   // Post-scale unit status
   typedef struct packed {
      logic done;
   } scale_status_type;

endpackage

[rtl/frd_mac.sv]
// Shared multiply-accumulate unit: one coefficient times one delayed sample per cycle.
`timescale 1ns / 1ps
module frd_mac #(
   parameter int COEF_BITS   = frd_pkg::COEF_BITS_DEF,
   parameter int SAMPLE_BITS = frd_pkg::SAMPLE_BITS_DEF,
   parameter int ACC_W       = 41
) (
   input  logic                           clock,
   input  logic                           reset,
   input  frd_pkg::mac_ctl_type           ctl,
   input  logic signed [COEF_BITS-1:0]    coef,
   input  logic signed [SAMPLE_BITS-1:0]  sample,
   output logic signed [ACC_W-1:0]        acc,
   output logic                           busy
);
   import frd_pkg::*;

   localparam int PROD_W = COEF_BITS + SAMPLE_BITS;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_v_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   // Multiply the registered operands
   assign prod_in = coef * sample;

   // Clear on a new sample, else add each finished product
   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_v_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else begin
         prod_v_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc  = acc_ff;
   assign busy = prod_v_ff;

endmodule

[rtl/frd_scale.sv]
// Post-scale unit: clamp, gain multiply in two halves, round and saturate.
`timescale 1ns / 1ps
module frd_scale #(
   parameter int COEF_BITS   = frd_pkg::COEF_BITS_DEF,
   parameter int SAMPLE_BITS = frd_pkg::SAMPLE_BITS_DEF,
   parameter int ACC_W       = 41
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [ACC_W-1:0]          acc,
   input  logic [frd_pkg::GAIN_W-1:0]       gain,
   output frd_pkg::scale_status_type        status,
   output logic [SAMPLE_BITS-1:0]           sample_out,
   output logic                             clip
);
   import frd_pkg::*;

   localparam int EXT_W  = (ACC_W > CLAMP_W) ? ACC_W : CLAMP_W;
   localparam int OPA_W  = HALF_W + 1;
   localparam int OPB_W  = GAIN_W + 1;
   localparam int MPY_W  = OPA_W + OPB_W;
   localparam int SH     = COEF_BITS - 1 + GAIN_FRAC;
   localparam logic signed [Y_W-1:0] SAT_HI = Y_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [Y_W-1:0] SAT_LO = -SAT_HI - Y_W'(1);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LO   = 3'd1;
   localparam logic [2:0] PH_HI   = 3'd2;
   localparam logic [2:0] PH_SUM  = 3'd3;
   localparam logic [2:0] PH_SAT  = 3'd4;

   logic [2:0]               phase_ff, phase_in;
   logic                     done_ff;
   logic signed [EXT_W-1:0]  acc_ext, lim_pos, lim_neg, clamp_val;
   logic [CLAMP_W-1:0]       clamped_ff;
   logic signed [OPA_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [MPY_W-1:0]  prod_ff;
   logic signed [Y_W-1:0]    y_ff, y_in, y_shr, round_c;
   logic [SAMPLE_BITS-1:0]   smp_ff, smp_in;
   logic                     clip_ff, clip_in;

   // Clamp the sum to the symmetric 48-bit range
   assign acc_ext   = EXT_W'(acc);
   assign lim_pos   = $signed((EXT_W'(1) << (CLAMP_W - 1)) - EXT_W'(1));
   assign lim_neg   = -lim_pos;
   assign clamp_val = (acc_ext > lim_pos) ? lim_pos :
                      (acc_ext < lim_neg) ? lim_neg : acc_ext;

   // One multiplier: low half first, then signed high half
   assign op_a = (phase_ff == PH_HI) ?
                 $signed({clamped_ff[CLAMP_W-1], clamped_ff[CLAMP_W-1:HALF_W]}) :
                 $signed({1'b0, clamped_ff[HALF_W-1:0]});
   assign op_b = $signed({1'b0, gain});

   // Round to nearest, ties up, then floor shift
   assign round_c = $signed(Y_W'(1) << (SH - 1));
   assign y_shr   = y_ff >>> SH;

   always_comb begin
      y_in = y_ff;
      if (phase_ff == PH_HI) begin
         y_in = Y_W'(prod_ff) + round_c;
      end else if (phase_ff == PH_SUM) begin
         y_in = y_ff + (Y_W'(prod_ff) <<< HALF_W);
      end
   end

   // Saturate to the sample range
   always_comb begin
      smp_in  = y_shr[SAMPLE_BITS-1:0];
      clip_in = 1'b0;
      if (y_shr > SAT_HI) begin
         smp_in  = SAT_HI[SAMPLE_BITS-1:0];
         clip_in = 1'b1;
      end else if (y_shr < SAT_LO) begin
         smp_in  = SAT_LO[SAMPLE_BITS-1:0];
         clip_in = 1'b1;
      end
   end

   // Advance through the phases
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start) phase_in = PH_LO;
         end
         PH_LO:   phase_in = PH_HI;
         PH_HI:   phase_in = PH_SUM;
         PH_SUM:  phase_in = PH_SAT;
         PH_SAT:  phase_in = PH_IDLE;
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= (phase_ff == PH_SAT);
      end
   end

   always_ff @(posedge clock) begin
      if (start) clamped_ff <= clamp_val[CLAMP_W-1:0];
      prod_ff <= op_a * op_b;
      y_ff    <= y_in;
      if (phase_ff == PH_SAT) begin
         smp_ff  <= smp_in;
         clip_ff <= clip_in;
      end
   end

   assign status.done = done_ff;
   assign sample_out  = smp_ff;
   assign clip        = clip_ff;

endmodule

[rtl/fir_filter_ring_delay_line.sv]
// Top level of the direct-form FIR filter with a circular delay line.
`timescale 1ns / 1ps
`include "fir_filter_ring_delay_line_macros.svh"
// Mono FIR filter. A transfer with tuser high loads one Q1.17 coefficient into
// slot tap_index; a transfer with tuser low pushes a Q1.15 sample into the
// delay line, sums coefficient times delayed sample over the taps_in_use taps,
// scales by output_gain (Q4.12), rounds, saturates and sends one result with a
// clip flag. One shared multiply-accumulate runs one tap per cycle, fed by one
// read port on each of the coefficient and delay memories, followed by a
// post-scale that reuses one multiplier on two halves of the sum. A finished
// result waits in an output register while the next item is taken. After
// reset the delay line is zeroed in a pass over all MAX_TAPS slots during
// which no item is taken; load all coefficients before sending samples.
module fir_filter_ring_delay_line #(
   parameter int MAX_TAPS    = frd_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = frd_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = frd_pkg::COEF_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // tdata: sample_in, tap_index, tap_value, zero fill
   input  logic [((SAMPLE_BITS + frd_pkg::IDX_W + COEF_BITS + 7) / 8) * 8 - 1:0]
                                                  req_tdata,
   // tuser: mode
   input  logic                                   req_tuser,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: sample_out, zero fill
   output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // tuser: clipped
   output logic                                   rsp_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [frd_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [frd_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [frd_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);
   import frd_pkg::*;

   localparam int AW     = $clog2(MAX_TAPS);
   localparam int LEN_W  = $clog2(MAX_TAPS + 1);
   localparam int LCW    = (TAPS_W > LEN_W) ? TAPS_W : LEN_W;
   localparam int IDXW   = ((IDX_W > AW) ? IDX_W : AW) + 1;
   localparam int ACC_W  = COEF_BITS + SAMPLE_BITS + AW;
   localparam int RSP_W  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int IDX_LO = SAMPLE_BITS;
   localparam int COEF_LO = SAMPLE_BITS + IDX_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MAC   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_SCALE = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [AW-1:0]                 clr_ff, clr_in;
   logic [AW-1:0]                 wp_ff, wp_in;
   logic [AW-1:0]                 k_ff, k_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [AW-1:0]                 last_ff, last_in;
   logic                          rd_v_ff;
   logic [TAPS_W-1:0]             taps_ff;
   logic [GAIN_W-1:0]             gain_ff;
   logic                          out_v_ff, out_v_in;
   logic [SAMPLE_BITS-1:0]        out_smp_ff;
   logic                          out_clip_ff;

   logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] dly_mem  [MAX_TAPS];
   logic signed [COEF_BITS-1:0]   coef_q_ff;
   logic signed [SAMPLE_BITS-1:0] dly_q_ff;

   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic [IDX_W-1:0]              req_idx;
   logic signed [COEF_BITS-1:0]   req_coef;
   logic                          sample_acc, load_acc, idx_ok, coef_we;
   logic                          dly_we;
   logic [AW-1:0]                 dly_waddr;
   logic signed [SAMPLE_BITS-1:0] dly_wdata;
   logic [LCW-1:0]                taps_ext, len_ext;
   logic [AW-1:0]                 len_m1, wp_use;
   logic                          scale_start, out_load, csr_wr;

   mac_ctl_type                   mac_ctl;
   logic signed [ACC_W-1:0]       mac_acc;
   logic                          mac_busy;
   scale_status_type              scale_stat;
   logic [SAMPLE_BITS-1:0]        scale_smp;
   logic                          scale_clip;

   // Unpack the input transfer
   assign req_sample = $signed(req_tdata[SAMPLE_BITS-1:0]);
   assign req_idx    = req_tdata[IDX_LO+IDX_W-1:IDX_LO];
   assign req_coef   = $signed(req_tdata[COEF_LO+COEF_BITS-1:COEF_LO]);

   assign req_tready = (state_ff == ST_IDLE);
   assign sample_acc = req_tvalid && req_tready && !req_tuser;
   assign load_acc   = req_tvalid && req_tready && req_tuser;

   // Drop loads to slots past the end of the store
   assign idx_ok  = IDXW'(req_idx) < IDXW'(MAX_TAPS);
   assign coef_we = load_acc && idx_ok;

   // Delay length in use: zero acts as one, large values as MAX_TAPS
   assign taps_ext = LCW'(taps_ff);
   always_comb begin
      len_ext = taps_ext;
      if (taps_ext == '0) begin
         len_ext = LCW'(1);
      end else if (taps_ext > LCW'(MAX_TAPS)) begin
         len_ext = LCW'(MAX_TAPS);
      end
   end
   assign len_m1 = AW'(len_ext - LCW'(1));
   assign wp_use = (wp_ff > len_m1) ? '0 : wp_ff;

   // Delay line write port: zero pass after reset, else the new sample
   assign dly_we    = (state_ff == ST_CLEAR) || sample_acc;
   assign dly_waddr = (state_ff == ST_CLEAR) ? clr_ff : wp_use;
   assign dly_wdata = (state_ff == ST_CLEAR) ? '0 : req_sample;

   assign scale_start = (state_ff == ST_DRAIN) && !rd_v_ff && !mac_busy;
   assign out_load    = (state_ff == ST_EMIT) && (!out_v_ff || rsp_tready);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      wp_in    = wp_ff;
      k_in     = k_ff;
      pos_in   = pos_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_TAPS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (sample_acc) begin
               k_in     = '0;
               pos_in   = wp_use;
               last_in  = len_m1;
               wp_in    = (wp_use == len_m1) ? '0 : wp_use + AW'(1);
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            // Walk taps forward and the ring backward
            if (k_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               k_in   = k_ff + AW'(1);
               pos_in = (pos_ff == '0) ? last_ff : pos_ff - AW'(1);
            end
         end
         ST_DRAIN: begin
            if (scale_start) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (scale_stat.done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Hold the result until the transfer completes
   always_comb begin
      out_v_in = out_v_ff;
      if (out_load) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         wp_ff    <= '0;
         rd_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         taps_ff  <= TAPS_RST;
         gain_ff  <= GAIN_RST;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         wp_ff    <= wp_in;
         rd_v_ff  <= (state_ff == ST_MAC);
         out_v_ff <= out_v_in;
         if (csr_wr && (csr_paddr[2] == REG_TAPS)) taps_ff <= csr_pwdata[TAPS_W-1:0];
         if (csr_wr && (csr_paddr[2] == REG_GAIN)) gain_ff <= csr_pwdata[GAIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      pos_ff  <= pos_in;
      last_ff <= last_in;
      if (out_load) begin
         out_smp_ff  <= scale_smp;
         out_clip_ff <= scale_clip;
      end
   end

   // Coefficient memory
   always_ff @(posedge clock) begin
      if (coef_we) coef_mem[AW'(req_idx)] <= req_coef;
      coef_q_ff <= coef_mem[k_ff];
   end

   // Delay line memory
   always_ff @(posedge clock) begin
      if (dly_we) dly_mem[dly_waddr] <= dly_wdata;
      dly_q_ff <= dly_mem[pos_ff];
   end

   assign mac_ctl.clear = sample_acc;
   assign mac_ctl.valid = rd_v_ff;

   frd_mac #(
      .COEF_BITS   (COEF_BITS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_W       (ACC_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .coef   (coef_q_ff),
      .sample (dly_q_ff),
      .acc    (mac_acc),
      .busy   (mac_busy)
   );

   frd_scale #(
      .COEF_BITS   (COEF_BITS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_W       (ACC_W)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .start      (scale_start),
      .acc        (mac_acc),
      .gain       (gain_ff),
      .status     (scale_stat),
      .sample_out (scale_smp),
      .clip       (scale_clip)
   );

   // Register read-back
   always_comb begin
      case (csr_paddr[2])
         REG_TAPS: csr_prdata = CSR_DATA_W'(taps_ff);
         REG_GAIN: csr_prdata = CSR_DATA_W'(gain_ff);
         default:  csr_prdata = '0;
      endcase
   end
   assign csr_pready = 1'b1;

   assign rsp_tdata  = RSP_W'(out_smp_ff);
   assign rsp_tuser  = out_clip_ff;
   assign rsp_tvalid = out_v_ff;

   `FRD_ASSERT_NOW(a_done_in_scale, clock, reset, scale_stat.done, state_ff == ST_SCALE, "post-scale finished outside its wait state")
   `FRD_ASSERT_NOW(a_issue_bound, clock, reset, state_ff == ST_MAC, k_ff <= last_ff, "tap index ran past the last tap")
   `FRD_ASSERT_NEXT(a_load_one_cycle, clock, reset, load_acc, state_ff == ST_IDLE, "coefficient load left idle")
   `FRD_ASSERT_NOW(a_no_overwrite, clock, reset, out_load, !out_v_ff || rsp_tready, "pending result overwritten")

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the ring-delay-line FIR filter.
`timescale 1ns / 1ps
module tb_top;
   import frd_pkg::*;

   localparam int NUM_TAPS = MAX_TAPS_DEF;
   localparam int SMP_W    = SAMPLE_BITS_DEF;
   localparam int COEF_W   = COEF_BITS_DEF;
   localparam int REQ_W    = ((SMP_W + IDX_W + COEF_W + 7) / 8) * 8;
   localparam int RSP_W    = ((SMP_W + 7) / 8) * 8;
   localparam int FILL_W   = REQ_W - SMP_W - IDX_W - COEF_W;
   localparam int SCALE_SH = COEF_W - 1 + GAIN_FRAC;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_LOAD   = 1'b1;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TAPS = {REG_TAPS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_GAIN = {REG_GAIN, 2'b00};

   localparam int SETTLE_CYCLES = NUM_TAPS + 40;
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int MAX_SHOWN     = 10;
   localparam int NUM_PHASES    = 17;
   localparam int QUIET_PHASES  = 3;

   typedef struct {
      logic                     mode;
      logic signed [SMP_W-1:0]  smp;
      logic [IDX_W-1:0]         idx;
      logic signed [COEF_W-1:0] coef;
   } fir_req_type;

   typedef struct {
      logic signed [SMP_W-1:0] smp;
      logic                    clip;
   } fir_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [REQ_W-1:0]      req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Filter state mirrored in the testbench
   logic signed [COEF_W-1:0] coef_mem [NUM_TAPS];
   logic signed [SMP_W-1:0]  sample_hist [NUM_TAPS];
   int unsigned              hist_pos = 0;
   logic [TAPS_W-1:0]        cfg_taps = TAPS_RST;
   logic [GAIN_W-1:0]        cfg_gain = GAIN_RST;

   fir_req_type pend_q[$];
   fir_rsp_type filtered_q[$];
   fir_req_type cur_req;

   bit idle_on = 1'b1;
   int src_gap = 0;
   int sink_gap = 0;
   int err_cnt = 0;
   int sample_cnt = 0;
   int load_cnt = 0;
   int clip_cnt = 0;
   int result_cnt = 0;
   int cycle_cnt = 0;

   fir_filter_ring_delay_line u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void flag_error(input string what);
      err_cnt++;
      if (err_cnt <= MAX_SHOWN) $display("tb_top: mismatch: %s", what);
   endfunction

   // Push one sample through the mirrored delay line and compute its output
   function automatic fir_rsp_type filter_sample(input logic signed [SMP_W-1:0] smp);
      fir_rsp_type res;
      int unsigned len;
      int unsigned p;
      int unsigned k;
      longint      acc;
      longint      y;
      longint      lim;
      len = cfg_taps;
      if (len > NUM_TAPS) len = NUM_TAPS;
      if (len == 0) len = 1;
      if (hist_pos >= len) hist_pos = 0;
      sample_hist[hist_pos] = smp;
      acc = 0;
      p = hist_pos;
      for (k = 0; k < len; k++) begin
         acc += longint'(coef_mem[k]) * longint'(sample_hist[p]);
         p = (p == 0) ? len - 1 : p - 1;
      end
      lim = 64'sh7FFF_FFFF_FFFF;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      // scale, round half up, then saturate
      y = acc * longint'(cfg_gain);
      y = (y + (64'sd1 <<< (SCALE_SH - 1))) >>> SCALE_SH;
      res.clip = 1'b1;
      if (y > 32767) res.smp = 16'sh7FFF;
      else if (y < -32768) res.smp = 16'sh8000;
      else begin
         res.smp = y[SMP_W-1:0];
         res.clip = 1'b0;
      end
      hist_pos = (hist_pos + 1) % len;
      return res;
   endfunction

   function automatic logic signed [COEF_W-1:0] rand_coef(input int style);
      if (style == 0) return COEF_W'($urandom());
      return COEF_W'($urandom_range(0, 4095) - 2048);
   endfunction

   function automatic logic signed [SMP_W-1:0] rand_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return SMP_W'($urandom());
      if (pick < 8) return SMP_W'($urandom_range(0, 2047) - 1024);
      return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
   endfunction

   task automatic push_load(input int idx, input logic signed [COEF_W-1:0] val);
      fir_req_type it;
      it.mode = MODE_LOAD;
      it.smp = SMP_W'($urandom());
      it.idx = idx[IDX_W-1:0];
      it.coef = val;
      pend_q.push_back(it);
   endtask

   task automatic push_sample(input logic signed [SMP_W-1:0] val);
      fir_req_type it;
      it.mode = MODE_SAMPLE;
      it.smp = val;
      it.idx = IDX_W'($urandom());
      it.coef = COEF_W'($urandom());
      pend_q.push_back(it);
   endtask

   // Wait for every queued item and result to clear, then let the block settle
   task automatic wait_drained();
      do @(posedge clock);
      while (pend_q.size() != 0 || req_tvalid || filtered_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write a register, read it back, and update the mirrored configuration
   task automatic set_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      logic [31:0] mask;
      mask = (addr == ADDR_TAPS) ? 32'h0000_00FF : 32'h0000_FFFF;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if ((csr_prdata & mask) !== (value & mask))
         flag_error($sformatf("register at %0d read 0x%0h, wrote 0x%0h",
                              addr, csr_prdata, value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_TAPS) cfg_taps = value[TAPS_W-1:0];
      else cfg_gain = value[GAIN_W-1:0];
   endtask

   // Request driver: apply accepted items to the mirror, then present the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (cur_req.mode == MODE_LOAD) begin
               coef_mem[cur_req.idx] = cur_req.coef;
               load_cnt++;
            end else begin
               filtered_q.push_back(filter_sample(cur_req.smp));
               sample_cnt++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
               cur_req = pend_q.pop_front();
               req_tdata <= {{FILL_W{1'b0}}, cur_req.coef, cur_req.idx, cur_req.smp};
               req_tuser <= cur_req.mode;
               req_tvalid <= 1'b1;
               if (idle_on && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 6);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each transfer with the oldest expected output
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_cnt++;
            if (rsp_tuser) clip_cnt++;
            if (filtered_q.size() == 0) begin
               flag_error($sformatf("unexpected result %0d clip %0b",
                                    $signed(rsp_tdata[SMP_W-1:0]), rsp_tuser));
            end else begin
               fir_rsp_type exp_rsp;
               exp_rsp = filtered_q.pop_front();
               if (rsp_tdata[SMP_W-1:0] !== exp_rsp.smp || rsp_tuser !== exp_rsp.clip)
                  flag_error($sformatf({"result %0d: sample_out exp %0d got %0d, ",
                                        "clipped exp %0b got %0b"},
                                       result_cnt, exp_rsp.smp, $signed(rsp_tdata[SMP_W-1:0]),
                                       exp_rsp.clip, rsp_tuser));
            end
         end
         if (sink_gap > 0) begin
            sink_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 6);
         end
      end
   end

   // Hard stop if the run hangs
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles", cycle_cnt);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      int ph;
      int n;
      int k;
      int len;
      int style;
      logic [31:0] taps_val;
      logic [31:0] gain_val;
      // start the mirrored delay line cleared
      for (k = 0; k < NUM_TAPS; k++) sample_hist[k] = '0;
      // hold reset, then load every coefficient before any sample
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      push_load(0, 18'sh1FFFF);
      push_load(1, 18'sh20000);
      for (k = 2; k < NUM_TAPS; k++) push_load(k, rand_coef(k % 2));
      // directed samples at reset settings
      push_sample(16'sh7FFF);
      push_sample(16'sh7FFF);
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      push_sample(16'sh8000);
      push_sample(16'sh0000);
      push_sample(16'sh0001);
      push_sample(16'shFFFF);
      push_sample(16'sh5555);
      push_sample(16'shAAAA);
      push_load(127, 18'sh00000);
      push_load(0, 18'sh00001);
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      push_sample(16'sh0000);
      for (n = 0; n < 60; n++) push_sample(rand_sample());
      wait_drained();

      for (ph = 1; ph < NUM_PHASES; ph++) begin
         idle_on = (ph < NUM_PHASES - QUIET_PHASES);
         // extremes of both registers first, then random settings
         case (ph)
            1: begin taps_val = 3;   gain_val = 4096;  end
            2: begin taps_val = 128; gain_val = 65535; end
            3: begin taps_val = 0;   gain_val = 0;     end
            4: begin taps_val = 1;   gain_val = 1;     end
            5: begin taps_val = 2;   gain_val = 12000; end
            6: begin taps_val = 255; gain_val = 2867;  end
            7: begin taps_val = 129; gain_val = 40000; end
            default: begin
               taps_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(3, 128);
               gain_val = $urandom_range(0, 65535);
            end
         endcase
         set_reg(ADDR_TAPS, taps_val);
         set_reg(ADDR_GAIN, gain_val);
         // sometimes swap in a fresh coefficient set for the taps in use
         if ($urandom_range(0, 3) == 0) begin
            len = (taps_val > NUM_TAPS) ? NUM_TAPS : taps_val;
            style = $urandom_range(0, 1);
            for (k = 0; k < len; k++) push_load(k, rand_coef(style));
         end
         for (n = 0; n < 50; n++) begin
            if ($urandom_range(0, 99) < 12)
               push_load($urandom_range(0, NUM_TAPS - 1), rand_coef($urandom_range(0, 1)));
            else
               push_sample(rand_sample());
         end
         wait_drained();
      end

      $display("tb_top: %0d phases, %0d samples filtered, %0d coefficient loads",
               NUM_PHASES, sample_cnt, load_cnt);
      $display("tb_top: %0d results checked, %0d saturated, %0d errors",
               result_cnt, clip_cnt, err_cnt);
      if (err_cnt == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
